// ===== src/assert_macros.svh =====
// Assertion macros shared by the resample table generator RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BRTG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define BRTG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BRTG_ASSERT(label, clk, rst_n, prop, msg)
`define BRTG_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/brtg_pkg.sv =====
// ----------------------------------------------------------------------------
// brtg_pkg
// Types and constants shared by the bilinear resample table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package brtg_pkg;

    localparam int WEIGHT_FRAC_BITS_DEFAULT = 15;
    localparam int QUEUE_DEPTH_DEFAULT      = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 30;
    localparam int STEP_FRAC   = 16;
    localparam int FRAC_W_MAX  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_COLUMNS   = 3'd0,
        REG_SRC_ROWS      = 3'd1,
        REG_COLUMN_STRIDE = 3'd2,
        REG_DEST_WIDTH    = 3'd3,
        REG_DEST_HEIGHT   = 3'd4,
        REG_COL_STEP      = 3'd5,
        REG_ROW_STEP      = 3'd6
    } cfg_reg_e;

    typedef struct packed {
        logic [10:0] src_columns;
        logic [13:0] src_rows;
        logic [14:0] column_stride;
        logic [12:0] dest_width;
        logic [12:0] dest_height;
        logic [26:0] col_step;
        logic [29:0] row_step;
    } cfg_t;

    typedef struct packed {
        logic [11:0] dest_col;
        logic [11:0] dest_row;
    } req_t;

    typedef struct packed {
        logic [23:0] pixel_pos;
        logic [23:0] table_slot;
        logic [15:0] weight_a;
        logic [15:0] weight_b;
        logic [15:0] weight_c;
        logic [15:0] weight_d;
        logic [23:0] index_a;
        logic [23:0] index_b;
        logic [23:0] index_c;
        logic [23:0] index_d;
    } resp_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic [23:0]           pixel_pos;
        logic [23:0]           table_slot;
        logic [10:0]           col_base;
        logic [10:0]           col_next;
        logic [13:0]           row_base;
        logic [13:0]           row_next;
        logic [FRAC_W_MAX-1:0] u;
        logic [FRAC_W_MAX-1:0] v;
    } q_item_t;

    // Free space in the queue: roomN is set when at least N entries are free.
    typedef struct packed {
        logic room1;
        logic room2;
        logic room3;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== src/brtg_front.sv =====
// ----------------------------------------------------------------------------
// brtg_front
// Front end: accepts destination pixels, forms the Q23.16 column and Q26.16 row source positions
// and splits them into clamped base/next coordinates and fractions.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module brtg_front
    import brtg_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          start,
    input  wire req_t          cmd,
    output logic               busy,
    input  wire queue_status_t qstat,
    output logic               push,
    output q_item_t            push_item
);

    localparam int FRAC_SHIFT = STEP_FRAC - WEIGHT_FRAC_BITS;

    logic accept;

    // Stage 1: products.
    logic        s1_valid_reg;
    logic [38:0] s1_full_c_reg;
    logic [41:0] s1_full_r_reg;
    logic [23:0] s1_pixel_pos_reg;
    logic [23:0] s1_table_slot_reg;

    logic [38:0] full_c_next;
    logic [41:0] full_r_next;
    logic [24:0] pix_prod;
    logic [24:0] slot_prod;
    logic [23:0] pixel_pos_next;
    logic [23:0] table_slot_next;

    // Stage 2: classified item.
    logic    s2_valid_reg;
    q_item_t s2_item_reg;
    q_item_t item_next;

    logic [10:0] last_c;
    logic [13:0] last_r;
    logic [22:0] ip_c;
    logic [25:0] ip_r;
    logic [10:0] base_c;
    logic [13:0] base_r;
    logic [15:0] fp_c;
    logic [15:0] fp_r;

    // Credit check: the new item and every item already in the front end need a free entry.
    always_comb
    begin
        case ({s1_valid_reg, s2_valid_reg})
            2'b00:   busy = !qstat.room1;
            2'b11:   busy = !qstat.room3;
            default: busy = !qstat.room2;
        endcase
    end

    assign accept = start && !busy;

    always_comb
    begin
        full_c_next     = {27'd0, cmd.dest_col} * {12'd0, cfg.col_step};
        full_r_next     = {30'd0, cmd.dest_row} * {12'd0, cfg.row_step};
        pix_prod        = {13'd0, cmd.dest_row} * {12'd0, cfg.dest_width};
        slot_prod       = {13'd0, cmd.dest_col} * {12'd0, cfg.dest_height};
        pixel_pos_next  = pix_prod[23:0] + {12'd0, cmd.dest_col};
        table_slot_next = slot_prod[23:0] + {12'd0, cmd.dest_row};
    end

    always_comb
    begin
        // A zero source size behaves as a size of one.
        last_c = (cfg.src_columns == 11'd0) ? 11'd0 : cfg.src_columns - 11'd1;
        last_r = (cfg.src_rows == 14'd0) ? 14'd0 : cfg.src_rows - 14'd1;
        ip_c   = s1_full_c_reg[38:STEP_FRAC];
        ip_r   = s1_full_r_reg[41:STEP_FRAC];

        // Positions past the last source sample saturate with zero fraction.
        if (ip_c > {12'd0, last_c})
        begin
            base_c = last_c;
            fp_c   = 16'd0;
        end
        else
        begin
            base_c = ip_c[10:0];
            fp_c   = s1_full_c_reg[STEP_FRAC-1:0];
        end

        if (ip_r > {12'd0, last_r})
        begin
            base_r = last_r;
            fp_r   = 16'd0;
        end
        else
        begin
            base_r = ip_r[13:0];
            fp_r   = s1_full_r_reg[STEP_FRAC-1:0];
        end

        item_next.pixel_pos  = s1_pixel_pos_reg;
        item_next.table_slot = s1_table_slot_reg;
        item_next.col_base   = base_c;
        item_next.col_next   = (base_c < last_c) ? base_c + 11'd1 : base_c;
        item_next.row_base   = base_r;
        item_next.row_next   = (base_r < last_r) ? base_r + 14'd1 : base_r;
        item_next.u          = FRAC_W_MAX'(fp_c >> FRAC_SHIFT);
        item_next.v          = FRAC_W_MAX'(fp_r >> FRAC_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_full_c_reg     <= full_c_next;
            s1_full_r_reg     <= full_r_next;
            s1_pixel_pos_reg  <= pixel_pos_next;
            s1_table_slot_reg <= table_slot_next;
        end
        if (s1_valid_reg)
        begin
            s2_item_reg <= item_next;
        end
    end

    assign push      = s2_valid_reg;
    assign push_item = s2_item_reg;

    `BRTG_ASSERT(a_accept_reaches_queue, clk, rst_n, accept |-> ##2 push, "accepted transaction did not reach the queue")
    `BRTG_ASSERT_NEVER(a_push_without_room, clk, rst_n, push && !qstat.room1 && !$past(s1_valid_reg && !qstat.room1), "push into a full queue")

endmodule

`default_nettype wire

// ===== src/brtg_queue.sv =====
// ----------------------------------------------------------------------------
// brtg_queue
// Short flop-based FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module brtg_queue
    import brtg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_item_t  push_item,
    output queue_status_t qstat,
    output logic          pop,
    output q_item_t       head_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // The back end never stalls, so the head leaves whenever there is one.
    assign pop       = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    assign qstat.room1 = (int'(count_reg) + 1) <= DEPTH;
    assign qstat.room2 = (int'(count_reg) + 2) <= DEPTH;
    assign qstat.room3 = (int'(count_reg) + 3) <= DEPTH;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `BRTG_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !pop && (int'(count_reg) == DEPTH), "queue overflow")
    `BRTG_ASSERT(a_count_tracks, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue level lost a transaction")

endmodule

`default_nettype wire

// ===== src/brtg_back.sv =====
// ----------------------------------------------------------------------------
// brtg_back
// Back end: forms the four corner weights and source indices for one
// classified item and registers the finished table entry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module brtg_back
    import brtg_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    pop,
    input  wire q_item_t head_item,
    output logic         done,
    output resp_t        result
);

    localparam int WF     = WEIGHT_FRAC_BITS;
    localparam int PROD_W = 2 * (WF + 1);
    localparam logic [WF:0] ONE = {1'b1, {WF{1'b0}}};

    logic [WF:0]       u;
    logic [WF:0]       v;
    logic [WF:0]       nu;
    logic [WF:0]       nv;
    logic [25:0]       col_base_prod;
    logic [25:0]       col_next_prod;

    logic              b1_valid_reg;
    logic [PROD_W-1:0] b1_p_a_reg;
    logic [PROD_W-1:0] b1_p_b_reg;
    logic [PROD_W-1:0] b1_p_c_reg;
    logic [PROD_W-1:0] b1_p_d_reg;
    logic [23:0]       b1_col_base_reg;
    logic [23:0]       b1_col_next_reg;
    logic [13:0]       b1_row_base_reg;
    logic [13:0]       b1_row_next_reg;
    logic [23:0]       b1_pixel_pos_reg;
    logic [23:0]       b1_table_slot_reg;

    logic              done_reg;
    resp_t             result_reg;
    resp_t             result_next;

    always_comb
    begin
        u  = {1'b0, head_item.u[WF-1:0]};
        v  = {1'b0, head_item.v[WF-1:0]};
        nu = ONE - u;
        nv = ONE - v;
        col_base_prod = {15'd0, head_item.col_base} * {11'd0, cfg.column_stride};
        col_next_prod = {15'd0, head_item.col_next} * {11'd0, cfg.column_stride};
    end

    always_comb
    begin
        result_next.pixel_pos  = b1_pixel_pos_reg;
        result_next.table_slot = b1_table_slot_reg;
        result_next.weight_a   = 16'(b1_p_a_reg >> WF);
        result_next.weight_b   = 16'(b1_p_b_reg >> WF);
        result_next.weight_c   = 16'(b1_p_c_reg >> WF);
        result_next.weight_d   = 16'(b1_p_d_reg >> WF);
        result_next.index_a    = b1_col_base_reg + {10'd0, b1_row_base_reg};
        result_next.index_b    = b1_col_base_reg + {10'd0, b1_row_next_reg};
        result_next.index_c    = b1_col_next_reg + {10'd0, b1_row_base_reg};
        result_next.index_d    = b1_col_next_reg + {10'd0, b1_row_next_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= pop;
            done_reg     <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_p_a_reg        <= PROD_W'(nu) * PROD_W'(nv);
            b1_p_b_reg        <= PROD_W'(nu) * PROD_W'(v);
            b1_p_c_reg        <= PROD_W'(u) * PROD_W'(nv);
            b1_p_d_reg        <= PROD_W'(u) * PROD_W'(v);
            b1_col_base_reg   <= col_base_prod[23:0];
            b1_col_next_reg   <= col_next_prod[23:0];
            b1_row_base_reg   <= head_item.row_base;
            b1_row_next_reg   <= head_item.row_next;
            b1_pixel_pos_reg  <= head_item.pixel_pos;
            b1_table_slot_reg <= head_item.table_slot;
        end
        if (b1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `BRTG_ASSERT(a_pop_to_done, clk, rst_n, pop |-> ##2 done, "popped transaction did not complete")
    `BRTG_ASSERT(a_done_has_source, clk, rst_n, done |-> $past(pop, 2), "result strobe without a popped transaction")

endmodule

`default_nettype wire

// ===== src/bilinear_resample_table_gen_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_resample_table_gen_unit
// Produces one bilinear resize table entry per destination pixel.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Handshake                 Payload
//  cmd          in         start && !busy            req_t  (dest_col, dest_row)
//  result       out        done, one cycle           resp_t (positions, weights, indices)
//  cfg          in         cfg_we                    cfg_index, cfg_data
//
//  One transaction is accepted per clock while busy is low; its result is
//  registered through the product and classify registers, the queue, and
//  the weight/index and result registers, and entries come out in order.
//  The path runs through two multiply stages and the queue hop: product and
//  classify in the front end, weight/index multiply and final add in the
//  back end.  busy rises only when the queue lacks free entries for the new
//  item and the items still in the front end; the result side cannot stall,
//  so in steady state busy stays low.  Reset clears control state and loads
//  the register defaults; no clearing pass is needed.
`default_nettype none

module bilinear_resample_table_gen_unit
    import brtg_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEFAULT,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   start,
    input  wire req_t                   cmd,
    output logic                        busy,
    output logic                        done,
    output resp_t                       result
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    queue_status_t qstat;
    logic          push;
    q_item_t       push_item;
    logic          pop;
    q_item_t       head_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_SRC_COLUMNS:   cfg_next.src_columns   = cfg_data[10:0];
                REG_SRC_ROWS:      cfg_next.src_rows      = cfg_data[13:0];
                REG_COLUMN_STRIDE: cfg_next.column_stride = cfg_data[14:0];
                REG_DEST_WIDTH:    cfg_next.dest_width    = cfg_data[12:0];
                REG_DEST_HEIGHT:   cfg_next.dest_height   = cfg_data[12:0];
                REG_COL_STEP:      cfg_next.col_step      = cfg_data[26:0];
                REG_ROW_STEP:      cfg_next.row_step      = cfg_data[29:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_columns   <= 11'd1;
            cfg_reg.src_rows      <= 14'd1;
            cfg_reg.column_stride <= 15'd1;
            cfg_reg.dest_width    <= 13'd2;
            cfg_reg.dest_height   <= 13'd2;
            cfg_reg.col_step      <= 27'd0;
            cfg_reg.row_step      <= 30'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brtg_front #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .qstat    (qstat),
        .push     (push),
        .push_item(push_item)
    );

    brtg_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .qstat    (qstat),
        .pop      (pop),
        .head_item(head_item)
    );

    brtg_back #(
        .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pop      (pop),
        .head_item(head_item),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire
